// File: rtl/tfr_pkg.sv
// shared types and constants of the telemetry frame receiver
`timescale 1ns / 1ps

package tfr_pkg;

    // frame geometry: start byte, data bytes 1..33, checksum byte
    localparam int FRAME_BYTES = 35;
    localparam int DATA_LAST   = FRAME_BYTES - 2;
    localparam int POS_W       = 6;
    localparam logic [POS_W-1:0] POS_HUNT = POS_W'(0);
    localparam logic [POS_W-1:0] POS_DATA_LAST = POS_W'(DATA_LAST);
    localparam logic [POS_W-1:0] POS_CHECK = POS_W'(FRAME_BYTES - 1);

    localparam logic [7:0]  START_CHAR = 8'h53;
    localparam logic [7:0]  MODE_PARK  = 8'h50;
    localparam logic [7:0]  MODE_AUTO  = 8'h41;
    localparam logic [7:0]  MODE_SPORT = 8'h53;
    localparam logic [11:0] YEAR_BASE  = 12'd2000;
    localparam logic [2:0]  DIST_MASK  = 3'h7;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_NEUTRAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT   = 2'd2;

    // gear position codes
    localparam logic [2:0] GP_PARK    = 3'd0;
    localparam logic [2:0] GP_NEUTRAL = 3'd1;
    localparam logic [2:0] GP_REVERSE = 3'd2;
    localparam logic [2:0] GP_AUTO    = 3'd3;
    localparam logic [2:0] GP_MANUAL  = 3'd4;
    localparam logic [2:0] GP_SPORT   = 3'd5;

    // frame byte k (1..33) sits at index k
    typedef logic [DATA_LAST:1][7:0] t_frame_bytes;

    typedef struct packed {
        logic at_check;   // next accepted byte is the checksum
        logic sum_ok;     // presented byte equals the running sum
    } t_frame_stat;

    typedef struct packed {
        logic [7:0] neutral_code;
        logic [7:0] reverse_code;
        logic [5:0] gear_limit;
    } t_cfg;

    typedef struct packed {
        logic        frame_status;
        logic [51:0] time_packed;
        logic [47:0] motion_packed;
        logic [31:0] temps_packed;
        logic [32:0] warning_flags;
        logic [7:0]  extra_flags;
        logic [32:0] lights_packed;
        logic [21:0] cruise_packed;
        logic [1:0]  indicator;
        logic [2:0]  gear_position;
        logic [5:0]  manual_gear;
        logic [8:0]  power_packed;
    } t_result;

endpackage

// File: rtl/tfr_framer.sv
// start hunt, byte position, running checksum and shift line of frame bytes
`timescale 1ns / 1ps

module tfr_framer import tfr_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_take,
    input  logic [7:0]   i_byte,
    output t_frame_stat  o_stat,
    output t_frame_bytes o_bytes
);

    logic [POS_W-1:0] r_pos, n_pos;
    logic [7:0]       r_sum, n_sum;
    t_frame_bytes     r_bytes;

    always_comb begin
        n_pos = r_pos;
        n_sum = r_sum;
        if (i_take) begin
            if (r_pos == POS_HUNT) begin
                if (i_byte == START_CHAR) begin
                    n_pos = POS_W'(1);
                    n_sum = '0;
                end
            end else if (r_pos == POS_CHECK) begin
                n_pos = POS_HUNT;
            end else begin
                n_pos = r_pos + POS_W'(1);
                n_sum = r_sum + i_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_HUNT;
            r_sum <= '0;
        end else begin
            r_pos <= n_pos;
            r_sum <= n_sum;
        end
    end

    // data bytes enter at the top; after byte 33 byte k is at index k
    always_ff @(posedge i_clk) begin
        if (i_take && r_pos != POS_HUNT && r_pos != POS_CHECK) begin
            for (int i = 1; i < DATA_LAST; i++) begin
                r_bytes[i] <= r_bytes[i+1];
            end
            r_bytes[DATA_LAST] <= i_byte;
        end
    end

    assign o_stat.at_check = (r_pos == POS_CHECK);
    assign o_stat.sum_ok   = (r_sum == i_byte);
    assign o_bytes         = r_bytes;

    property p_pos_range;
        @(posedge i_clk) disable iff (!i_rst_n) r_pos <= POS_CHECK;
    endproperty
    a_pos_range: assert property (p_pos_range)
        else $error("byte position out of range");

    property p_start_only;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_pos == POS_HUNT && i_take && i_byte != START_CHAR) |=> r_pos == POS_HUNT;
    endproperty
    a_start_only: assert property (p_start_only)
        else $error("frame started without start byte");

    property p_wrap;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_pos == POS_CHECK && i_take) |=> r_pos == POS_HUNT;
    endproperty
    a_wrap: assert property (p_wrap)
        else $error("no return to hunting after checksum");

endmodule

// File: rtl/tfr_decoder.sv
// field decode of a complete frame into the packed result
`timescale 1ns / 1ps

module tfr_decoder import tfr_pkg::*; (
    input  t_frame_bytes i_bytes,
    input  t_cfg         i_cfg,
    output t_result      o_result
);

    logic [31:0] w_flags;
    logic [32:0] w_flags_out;
    logic [7:0]  w_gear;
    logic [7:0]  w_mode;
    logic [7:0]  w_cm;
    logic [2:0]  w_dist;
    logic [7:0]  w_gear_m1;
    logic [2:0]  w_pos;
    logic [5:0]  w_mg;

    assign w_flags = {i_bytes[19], i_bytes[18], i_bytes[17], i_bytes[16]};
    assign w_gear  = i_bytes[11];
    assign w_mode  = i_bytes[26];
    assign w_cm    = i_bytes[29];

    // all four tires low folds into one all-deflated bit
    always_comb begin
        w_flags_out = {1'b0, w_flags};
        if (&w_flags[21:18]) begin
            w_flags_out[21:18] = '0;
            w_flags_out[32]    = 1'b1;
        end
    end

    always_comb begin
        w_dist = w_cm[5:3] & DIST_MASK;
        if (w_dist == 3'd0 || w_dist > 3'd4) begin
            w_dist = '0;
        end
    end

    assign w_gear_m1 = w_gear - 8'd1;

    always_comb begin
        w_mg = '0;
        priority if (w_mode == MODE_PARK) begin
            w_pos = GP_PARK;
        end else if (w_gear == i_cfg.neutral_code) begin
            w_pos = GP_NEUTRAL;
        end else if (w_gear == i_cfg.reverse_code) begin
            w_pos = GP_REVERSE;
        end else if (w_mode == MODE_AUTO) begin
            w_pos = GP_AUTO;
        end else begin
            w_pos = (w_mode == MODE_SPORT) ? GP_SPORT : GP_MANUAL;
            if (w_gear != 8'd0) begin
                if (w_gear_m1 > {2'b00, i_cfg.gear_limit}) begin
                    w_mg = i_cfg.gear_limit;
                end else begin
                    w_mg = w_gear_m1[5:0];
                end
            end
        end
    end

    always_comb begin
        o_result.frame_status  = 1'b0;
        o_result.time_packed   = {({4'h0, i_bytes[1]} + YEAR_BASE), i_bytes[2], i_bytes[3],
                                  i_bytes[4], i_bytes[5], i_bytes[6]};
        o_result.motion_packed = {i_bytes[8], i_bytes[7], i_bytes[10], i_bytes[9],
                                  i_bytes[15], i_bytes[14]};
        o_result.temps_packed  = {i_bytes[12], i_bytes[13], i_bytes[33], i_bytes[32]};
        o_result.warning_flags = w_flags_out;
        o_result.extra_flags   = i_bytes[20];
        o_result.lights_packed = {i_bytes[22], i_bytes[21], i_bytes[24], i_bytes[23],
                                  |i_bytes[25]};
        o_result.cruise_packed = {i_bytes[28], i_bytes[27], w_cm[0], w_cm[1], w_cm[2], w_dist};
        o_result.indicator     = {w_flags[6], w_flags[5]};
        o_result.gear_position = w_pos;
        o_result.manual_gear   = w_mg;
        o_result.power_packed  = {|i_bytes[31], i_bytes[30]};
    end

endmodule

// File: rtl/telemetry_frame_receiver.sv
// top level of the telemetry frame receiver
`timescale 1ns / 1ps

// telemetry frame receiver: takes one received byte per request, at most one per
// cycle, with no gaps needed. bytes are dropped until an 'S' starts a frame of 35
// bytes; bytes 1..33 are summed mod 256 and byte 34 is the checksum. a result
// request appears on the output the cycle after the checksum byte is accepted.
// the framer keeps the data bytes in a 33-byte shift line, and the decoder works
// on those fixed taps in the same cycle the checksum arrives, feeding the output
// register. on a checksum mismatch o_frame_status is 1 and all other fields are
// zero. the input side stalls only when the checksum byte is presented while an
// earlier result still waits in the output register; every other byte is taken
// even under output back-pressure.
// configuration (neutral code, reverse code, gear limit) is written through the
// cfg channel, which is always ready; indexes past the last register are ignored.

module telemetry_frame_receiver import tfr_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // byte input
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [7:0]           i_byte_in,
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_data,
    // result output
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_frame_status,
    output logic [51:0]          o_time_packed,
    output logic [47:0]          o_motion_packed,
    output logic [31:0]          o_temps_packed,
    output logic [32:0]          o_warning_flags,
    output logic [7:0]           o_extra_flags,
    output logic [32:0]          o_lights_packed,
    output logic [21:0]          o_cruise_packed,
    output logic [1:0]           o_indicator,
    output logic [2:0]           o_gear_position,
    output logic [5:0]           o_manual_gear,
    output logic [8:0]           o_power_packed
);

    t_cfg         r_cfg;
    t_frame_stat  w_stat;
    t_frame_bytes w_bytes;
    t_result      w_decoded;
    t_result      r_out, n_out;
    logic         r_out_valid;
    logic         w_take;
    logic         w_done;

    // configuration registers, written at any time the port is used
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.neutral_code <= 8'd0;
            r_cfg.reverse_code <= 8'd255;
            r_cfg.gear_limit   <= 6'd12;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_NEUTRAL: r_cfg.neutral_code <= i_cfg_data;
                CFG_REVERSE: r_cfg.reverse_code <= i_cfg_data;
                CFG_LIMIT:   r_cfg.gear_limit   <= i_cfg_data[5:0];
                default: begin
                    // no register at this index
                end
            endcase
        end
    end

    // only the checksum byte produces a result, so only it waits for space
    assign o_in_ready = !w_stat.at_check || !r_out_valid || i_out_ready;
    assign w_take     = i_in_valid && o_in_ready;
    assign w_done     = w_take && w_stat.at_check;

    tfr_framer u_framer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (w_take),
        .i_byte  (i_byte_in),
        .o_stat  (w_stat),
        .o_bytes (w_bytes)
    );

    tfr_decoder u_decoder (
        .i_bytes  (w_bytes),
        .i_cfg    (r_cfg),
        .o_result (w_decoded)
    );

    // mismatch gives status 1 with every other field cleared
    always_comb begin
        if (w_stat.sum_ok) begin
            n_out = w_decoded;
        end else begin
            n_out              = '0;
            n_out.frame_status = 1'b1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_frame_status  = r_out.frame_status;
    assign o_time_packed   = r_out.time_packed;
    assign o_motion_packed = r_out.motion_packed;
    assign o_temps_packed  = r_out.temps_packed;
    assign o_warning_flags = r_out.warning_flags;
    assign o_extra_flags   = r_out.extra_flags;
    assign o_lights_packed = r_out.lights_packed;
    assign o_cruise_packed = r_out.cruise_packed;
    assign o_indicator     = r_out.indicator;
    assign o_gear_position = r_out.gear_position;
    assign o_manual_gear   = r_out.manual_gear;
    assign o_power_packed  = r_out.power_packed;

    // a new result only follows an accepted checksum byte
    property p_result_source;
        @(posedge i_clk) disable iff (!i_rst_n)
            $rose(r_out_valid) |-> $past(w_done);
    endproperty
    a_result_source: assert property (p_result_source)
        else $error("result without checksum byte");

    // mismatch results carry nothing but the status
    property p_mismatch_clear;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_out_valid && r_out.frame_status) |->
                (r_out.time_packed == '0 && r_out.gear_position == '0 &&
                 r_out.warning_flags == '0 && r_out.manual_gear == '0);
    endproperty
    a_mismatch_clear: assert property (p_mismatch_clear)
        else $error("mismatch result has data fields");

    // manual gear only for the manual positions
    property p_manual_gear;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_out_valid && r_out.gear_position != GP_MANUAL &&
             r_out.gear_position != GP_SPORT) |-> r_out.manual_gear == '0;
    endproperty
    a_manual_gear: assert property (p_manual_gear)
        else $error("manual gear outside manual positions");

    // all-deflated bit replaces the tire bits
    property p_deflated;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_out_valid && r_out.warning_flags[32]) |-> r_out.warning_flags[21:18] == '0;
    endproperty
    a_deflated: assert property (p_deflated)
        else $error("tire bits left with all-deflated set");

endmodule

// File: sim/tb_telemetry_frame_receiver.sv
// testbench for the telemetry frame receiver: framed byte stimulus, scoreboard, result checks
`timescale 1ns / 1ps

// bytes go in through a bursty sender and results are taken by a receiver that
// stalls on its own pattern. a scoreboard class tracks the framer state and the
// register settings, decodes each completed frame, and compares every accepted
// result field by field with the oldest expected frame. registers change only
// between phases, once all expected frames have come out.

module tb_telemetry_frame_receiver;
    import tfr_pkg::*;

    // register index with no register behind it, writes must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    // a gear mode letter that is none of park, auto or sport
    localparam logic [7:0] MODE_OTHER = 8'h4D;
    // frame bytes per random phase
    localparam int PHASE_BYTES = 300;
    // idle margin after every expected frame has drained
    localparam int SETTLE_CYCLES = 4;

    class frame_scoreboard;
        t_cfg        cfg;
        logic [POS_W-1:0] pos;
        logic [7:0]  sum;
        logic [7:0]  pb [0:FRAME_BYTES-2];
        t_result     pending_frames [$];
        int          fault_count;
        int          decoded_count;

        function new();
            cfg.neutral_code = 8'd0;
            cfg.reverse_code = 8'd255;
            cfg.gear_limit   = 6'd12;
            pos = POS_HUNT;
            sum = 8'd0;
            fault_count = 0;
            decoded_count = 0;
        endfunction

        function void write_cfg(logic [CFG_IDX_W-1:0] idx, logic [7:0] d);
            case (idx)
                CFG_NEUTRAL: cfg.neutral_code = d;
                CFG_REVERSE: cfg.reverse_code = d;
                CFG_LIMIT:   cfg.gear_limit = d[5:0];
                default: ;
            endcase
        endfunction

        function logic [15:0] word16(int k);
            return {pb[k+1], pb[k]};
        endfunction

        function t_result decode_frame();
            t_result     r;
            logic [31:0] fl;
            logic [7:0]  cm;
            logic [2:0]  cdist;
            logic [7:0]  gear;
            logic [7:0]  mode;
            logic [7:0]  mg;
            logic [2:0]  gp;
            r = '0;
            r.time_packed = {YEAR_BASE + {4'h0, pb[1]}, pb[2], pb[3], pb[4], pb[5], pb[6]};
            r.motion_packed = {word16(7), word16(9), word16(14)};
            r.temps_packed = {pb[12], pb[13], word16(32)};
            fl = {pb[19], pb[18], pb[17], pb[16]};
            r.indicator = {fl[6], fl[5]};
            // all four tires flagged collapse into the all-deflated bit
            if (&fl[21:18]) begin
                fl[21:18] = 4'h0;
                r.warning_flags = {1'b1, fl};
            end else begin
                r.warning_flags = {1'b0, fl};
            end
            r.extra_flags = pb[20];
            r.lights_packed = {word16(21), word16(23), |pb[25]};
            cm = pb[29];
            cdist = cm[5:3];
            if (cdist == 3'd0 || cdist > 3'd4) begin
                cdist = 3'd0;
            end
            r.cruise_packed = {word16(27), cm[0], cm[1], cm[2], cdist};
            gear = pb[11];
            mode = pb[26];
            mg = 8'd0;
            if (mode == MODE_PARK) begin
                gp = GP_PARK;
            end else if (gear == cfg.neutral_code) begin
                gp = GP_NEUTRAL;
            end else if (gear == cfg.reverse_code) begin
                gp = GP_REVERSE;
            end else if (mode == MODE_AUTO) begin
                gp = GP_AUTO;
            end else begin
                gp = (mode == MODE_SPORT) ? GP_SPORT : GP_MANUAL;
                if (gear != 8'd0) begin
                    mg = gear - 8'd1;
                    if (mg > {2'b00, cfg.gear_limit}) begin
                        mg = {2'b00, cfg.gear_limit};
                    end
                end
            end
            r.gear_position = gp;
            r.manual_gear = mg[5:0];
            r.power_packed = {|pb[31], pb[30]};
            return r;
        endfunction

        // one accepted input byte
        function void note_byte(logic [7:0] b);
            t_result r;
            if (pos == POS_HUNT) begin
                if (b == START_CHAR) begin
                    pb[0] = b;
                    sum = 8'd0;
                    pos = POS_W'(1);
                end
            end else if (pos < POS_CHECK) begin
                pb[pos] = b;
                sum = sum + b;
                pos = pos + 1'b1;
            end else begin
                pos = POS_HUNT;
                if (sum != b) begin
                    r = '0;
                    r.frame_status = 1'b1;
                end else begin
                    r = decode_frame();
                end
                pending_frames.push_back(r);
            end
        endfunction

        function void compare_field(string fname, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                fault_count++;
                if (fault_count <= 10) begin
                    $display("%s mismatch: expected %h, got %h", fname, want, got);
                end
            end
        endfunction

        // one accepted result
        function void check_result(t_result got);
            t_result want;
            decoded_count++;
            if (pending_frames.size() == 0) begin
                fault_count++;
                if (fault_count <= 10) begin
                    $display("unexpected result, no frame pending: %h", got);
                end
                return;
            end
            want = pending_frames.pop_front();
            compare_field("frame_status", want.frame_status, got.frame_status);
            compare_field("time_packed", want.time_packed, got.time_packed);
            compare_field("motion_packed", want.motion_packed, got.motion_packed);
            compare_field("temps_packed", want.temps_packed, got.temps_packed);
            compare_field("warning_flags", want.warning_flags, got.warning_flags);
            compare_field("extra_flags", want.extra_flags, got.extra_flags);
            compare_field("lights_packed", want.lights_packed, got.lights_packed);
            compare_field("cruise_packed", want.cruise_packed, got.cruise_packed);
            compare_field("indicator", want.indicator, got.indicator);
            compare_field("gear_position", want.gear_position, got.gear_position);
            compare_field("manual_gear", want.manual_gear, got.manual_gear);
            compare_field("power_packed", want.power_packed, got.power_packed);
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic [7:0]           i_byte_in = 8'h00;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [7:0]           i_cfg_data = 8'h00;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic                 o_frame_status;
    logic [51:0]          o_time_packed;
    logic [47:0]          o_motion_packed;
    logic [31:0]          o_temps_packed;
    logic [32:0]          o_warning_flags;
    logic [7:0]           o_extra_flags;
    logic [32:0]          o_lights_packed;
    logic [21:0]          o_cruise_packed;
    logic [1:0]           o_indicator;
    logic [2:0]           o_gear_position;
    logic [5:0]           o_manual_gear;
    logic [8:0]           o_power_packed;

    frame_scoreboard sb;
    int burst_left = 0;      // requests left in the current sender burst
    int frame_bytes = 0;     // bytes sent inside intended frames

    telemetry_frame_receiver i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_byte_in       (i_byte_in),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_frame_status  (o_frame_status),
        .o_time_packed   (o_time_packed),
        .o_motion_packed (o_motion_packed),
        .o_temps_packed  (o_temps_packed),
        .o_warning_flags (o_warning_flags),
        .o_extra_flags   (o_extra_flags),
        .o_lights_packed (o_lights_packed),
        .o_cruise_packed (o_cruise_packed),
        .o_indicator     (o_indicator),
        .o_gear_position (o_gear_position),
        .o_manual_gear   (o_manual_gear),
        .o_power_packed  (o_power_packed)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // hard stop in case a handshake never completes
    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    // one byte request; bursts of random length, random gaps in between
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            // now and then a long run with no idling at all
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 40);
        end
        i_in_valid <= 1'b1;
        i_byte_in  <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_byte(b);
        burst_left--;
    endtask

    // start byte, 33 data bytes, then the sum or a deliberately wrong one
    task automatic send_frame(input t_frame_bytes fr, input bit bad_sum);
        logic [7:0] s;
        s = 8'd0;
        send_byte(START_CHAR);
        for (int k = 1; k <= DATA_LAST; k++) begin
            s = s + fr[k];
            send_byte(fr[k]);
        end
        send_byte(bad_sum ? s ^ 8'($urandom_range(1, 255)) : s);
        frame_bytes += FRAME_BYTES;
    endtask

    // one register write request
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_cfg(idx, d);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // stop sending and wait for every expected frame to drain
    task automatic settle();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (sb.pending_frames.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // random data bytes, biased toward the interesting gear, mode and flag cases
    function automatic t_frame_bytes random_frame();
        t_frame_bytes fr;
        for (int k = 1; k <= DATA_LAST; k++) begin
            fr[k] = 8'($urandom_range(0, 255));
        end
        case ($urandom_range(0, 5))
            0: fr[11] = sb.cfg.neutral_code;
            1: fr[11] = sb.cfg.reverse_code;
            2: fr[11] = 8'd0;
            3: fr[11] = 8'($urandom_range(1, 16));
            4: fr[11] = {2'b00, sb.cfg.gear_limit} + 8'($urandom_range(0, 2));
            default: ;
        endcase
        case ($urandom_range(0, 4))
            0: fr[26] = MODE_PARK;
            1: fr[26] = MODE_AUTO;
            2: fr[26] = MODE_SPORT;
            default: ;
        endcase
        // tire bits 18..21 of the flag word live in byte 18, bits 2..5
        if ($urandom_range(0, 2) == 0) begin
            fr[18][5:2] = 4'hF;
        end
        if ($urandom_range(0, 2) == 0) begin
            fr[25] = 8'd0;
        end
        if ($urandom_range(0, 2) == 0) begin
            fr[31] = 8'd0;
        end
        return fr;
    endfunction

    // receiver: takes results, stalls on windows of changing patterns and
    // twice holds off long enough for the block to stall its input
    initial begin
        int hold_left;
        int win_left;
        int rx_mode;
        hold_left = 0;
        win_left = 0;
        rx_mode = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                sb.check_result({o_frame_status, o_time_packed, o_motion_packed,
                                 o_temps_packed, o_warning_flags, o_extra_flags,
                                 o_lights_packed, o_cruise_packed, o_indicator,
                                 o_gear_position, o_manual_gear, o_power_packed});
                if (sb.decoded_count == 3 || sb.decoded_count == 25) begin
                    hold_left = 400;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                if (win_left == 0) begin
                    win_left = $urandom_range(16, 80);
                    rx_mode = $urandom_range(0, 3);
                end
                win_left--;
                case (rx_mode)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= 1'($urandom_range(0, 1));
                    2: i_out_ready <= ($urandom_range(0, 3) == 0);
                    default: i_out_ready <= ~i_out_ready;
                endcase
            end
        end
    end

    initial begin
        t_frame_bytes fr;
        sb = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part under reset settings
        // non-start bytes while hunting are dropped
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h52);
        // all-zero data, zero sum
        fr = '0;
        send_frame(fr, 1'b0);
        // all-ones data: tires all set, hazard, gear equals reverse code
        fr = '1;
        send_frame(fr, 1'b0);
        // checksum mismatch
        send_frame(fr, 1'b1);
        // start character inside the payload, sport mode, gear saturates at the limit
        fr = {DATA_LAST{START_CHAR}};
        send_frame(fr, 1'b0);
        fr = random_frame();
        fr[26] = MODE_PARK;
        send_frame(fr, 1'b0);
        fr = random_frame();
        fr[26] = MODE_AUTO;
        fr[11] = 8'd5;
        send_frame(fr, 1'b0);

        for (int p = 1; p <= 4; p++) begin
            settle();
            case (p)
                1: begin
                    // extremes: neutral and reverse swapped to the far ends, no manual gears
                    write_reg(CFG_NEUTRAL, 8'hFF);
                    write_reg(CFG_REVERSE, 8'h00);
                    write_reg(CFG_LIMIT, 8'h00);
                end
                2: begin
                    // neither code is zero, limit written with its top bits set
                    write_reg(CFG_NEUTRAL, 8'($urandom_range(1, 127)));
                    write_reg(CFG_REVERSE, 8'($urandom_range(128, 254)));
                    write_reg(CFG_LIMIT, 8'hFF);
                    write_reg(CFG_UNUSED, 8'($urandom_range(0, 255)));
                end
                3: begin
                    write_reg(CFG_NEUTRAL, 8'($urandom_range(0, 255)));
                    write_reg(CFG_REVERSE, 8'($urandom_range(0, 255)));
                    write_reg(CFG_LIMIT, 8'($urandom_range(0, 63)));
                end
                default: begin
                    write_reg(CFG_NEUTRAL, 8'd0);
                    write_reg(CFG_REVERSE, 8'd255);
                    write_reg(CFG_LIMIT, 8'd12);
                end
            endcase
            if (p == 2) begin
                // gear byte zero in a manual mode and in sport mode
                fr = random_frame();
                fr[26] = MODE_OTHER;
                fr[11] = 8'd0;
                send_frame(fr, 1'b0);
                fr[26] = MODE_SPORT;
                send_frame(fr, 1'b0);
            end
            while (frame_bytes < p * PHASE_BYTES) begin
                // noise between frames, now and then a stray start that breaks framing
                repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 255)));
                if ($urandom_range(0, 24) == 0) begin
                    send_byte(START_CHAR);
                end
                fr = random_frame();
                send_frame(fr, $urandom_range(0, 9) == 0);
            end
        end

        settle();
        repeat (20) @(posedge i_clk);
        if (sb.fault_count == 0 && sb.pending_frames.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
